// ----- src/eauv_pkg.sv -----
`default_nettype none

package eauv_pkg;

	// field widths
	localparam int ANGLE_BITS = 12;
	localparam int HI_BITS    = ANGLE_BITS - 8;
	localparam int TURN_W     = 32;
	localparam int TIME_W     = 32;
	localparam int POS_W      = TURN_W + ANGLE_BITS;
	localparam int VEL_W      = 32;
	localparam int THR_W      = 12;
	localparam int ZI_W       = 20;

	// configuration port
	localparam int CFG_DATA_W = 20;
	localparam int CFG_IDX_W  = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_WRAP_THRESHOLD = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_ZERO_INTERVAL  = 1'b1;
	localparam logic [THR_W-1:0] WRAP_THRESHOLD_RST = 12'd3277;
	localparam logic [ZI_W-1:0]  ZERO_INTERVAL_RST  = 20'd1000;

	// request commands
	localparam logic CMD_SAMPLE   = 1'b0;
	localparam logic CMD_VELOCITY = 1'b1;

	// velocity datapath
	localparam int DTURN_W   = TURN_W + 1;
	localparam int DANG_W    = ANGLE_BITS + 1;
	localparam int DCNT_W    = DTURN_W + ANGLE_BITS;
	localparam int DIGIT_W   = 4;
	localparam int MAG_W     = ((DCNT_W + DIGIT_W - 1) / DIGIT_W) * DIGIT_W;
	localparam int MUL_STEPS = MAG_W / DIGIT_W;
	localparam int MUL_CNT_W = $clog2(MUL_STEPS);
	localparam int US_PER_S  = 1000000;
	localparam int SCALE_W   = 20;
	localparam int SUM_W     = SCALE_W + DIGIT_W;
	localparam int PROD_W    = MAG_W + SCALE_W;
	localparam int QUOT_W    = VEL_W - 1;
	localparam int DIV_HI_W  = PROD_W - QUOT_W;
	localparam int REM_W     = TIME_W;
	localparam int TRIAL_W   = REM_W + 1;
	localparam int DIV_STEPS = QUOT_W;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	localparam logic [VEL_W-1:0] VEL_MAX = {1'b0, {QUOT_W{1'b1}}};
	localparam logic [VEL_W-1:0] VEL_MIN = {1'b1, {QUOT_W{1'b0}}};

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREP,
		ST_ABS,
		ST_MUL,
		ST_DIV,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic              cmd;
		logic [7:0]        angle_high_byte;
		logic [7:0]        angle_low_byte;
		logic [TIME_W-1:0] timestamp_us;
	} req_t;

	typedef struct packed {
		logic [ANGLE_BITS-1:0]  mechanical_angle;
		logic signed [TURN_W-1:0] turns;
		logic signed [POS_W-1:0]  position_counts;
		logic signed [VEL_W-1:0]  velocity_cps;
	} rsp_t;

	// one digit of the magnitude times one million
	function automatic logic [SUM_W-1:0] digit_scale(input logic [DIGIT_W-1:0] d);
		return SUM_W'(d) * SUM_W'(US_PER_S);
	endfunction

endpackage

`default_nettype wire

// ----- src/eauv_mul.sv -----
`default_nettype none

// digit-serial multiply of the count magnitude by one million
module eauv_mul import eauv_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [MAG_W-1:0]  mag,
	output logic                   done,
	output logic [PROD_W-1:0]      product
);

	logic [MAG_W-1:0]     m_q;
	logic [SCALE_W-1:0]   acc_q;
	logic [MAG_W-1:0]     lo_q;
	logic [MUL_CNT_W-1:0] cnt_q;
	logic                 run_q;
	logic                 done_q;
	logic [SUM_W-1:0]     sum;

	always_comb begin
		sum = SUM_W'(acc_q) + digit_scale(m_q[DIGIT_W-1:0]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == MUL_CNT_W'(MUL_STEPS - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// partial sum stays below one million, low digits shift out into lo_q
	always_ff @(posedge clk) begin
		if (start) begin
			m_q   <= mag;
			acc_q <= '0;
		end else if (run_q) begin
			m_q   <= m_q >> DIGIT_W;
			acc_q <= sum[SUM_W-1:DIGIT_W];
			lo_q  <= {sum[DIGIT_W-1:0], lo_q[MAG_W-1:DIGIT_W]};
		end
	end

	assign done    = done_q;
	assign product = {acc_q, lo_q};

endmodule

`default_nettype wire

// ----- src/eauv_div.sv -----
`default_nettype none

// restoring divider, one quotient bit per cycle, with up-front overflow check
module eauv_div import eauv_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [PROD_W-1:0] num,
	input  wire logic [TIME_W-1:0] den,
	output logic                   done,
	output logic                   ovf,
	output logic [QUOT_W-1:0]      quot
);

	logic [REM_W-1:0]     rem_q;
	logic [QUOT_W-1:0]    nq_q;
	logic                 ovf_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 run_q;
	logic                 done_q;
	logic                 ovf_now;
	logic [TRIAL_W-1:0]   trial;
	logic [TRIAL_W-1:0]   diff;
	logic                 ge;

	always_comb begin
		ovf_now = num[PROD_W-1:QUOT_W] >= DIV_HI_W'(den);
		trial   = {rem_q, nq_q[QUOT_W-1]};
		diff    = trial - TRIAL_W'(den);
		ge      = trial >= TRIAL_W'(den);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= '0;
				if (ovf_now) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end else begin
					run_q <= 1'b1;
				end
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// quotient bits shift in behind the dividend bits
	always_ff @(posedge clk) begin
		if (start) begin
			ovf_q <= ovf_now;
			rem_q <= num[QUOT_W+REM_W-1:QUOT_W];
			nq_q  <= num[QUOT_W-1:0];
		end else if (run_q) begin
			rem_q <= ge ? diff[REM_W-1:0] : trial[REM_W-1:0];
			nq_q  <= {nq_q[QUOT_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign ovf  = ovf_q;
	assign quot = nq_q;

endmodule

`default_nettype wire

// ----- src/encoder_angle_unwrap_velocity.sv -----
`default_nettype none

// Turn counter and velocity estimator for a 12-bit absolute angle sensor. A sample
// request (cmd 0) builds the angle from the low nibble of the high byte and the low
// byte, counts a turn down or up when the jump from the stored angle reaches
// wrap_threshold, and stores angle and timestamp; the first sample after reset only
// primes the state and the snapshot. A velocity request (cmd 1) returns the change in
// counts since the last snapshot times one million over the elapsed microseconds
// (zero_interval_us when no time passed, 1 if that register is 0), truncated toward
// zero and saturated to 32 bits, then renews the snapshot. Every request returns one
// response holding angle, turns, position (turns * 4096 + angle) and velocity (zero
// on a sample). A sample request goes straight to the final state, which loads the output
// register once it is free. A velocity request first forms the count difference and its
// magnitude, then runs a 4-bit digit-serial multiplier and a radix-2 restoring divider;
// when the quotient is sure to saturate the divider stops after its check. One request is
// in flight at a time; a new one is accepted while the previous response still waits on
// the output register.
module encoder_angle_unwrap_velocity import eauv_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// configuration writes
	input  wire logic                  cfg_wr_en,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
	// request channel
	input  wire logic                  req_valid,
	output logic                       req_ready,
	input  wire req_t                  req,
	// response channel
	output logic                       rsp_valid,
	input  wire logic                  rsp_ready,
	output rsp_t                       rsp
);

	// configuration registers
	logic [THR_W-1:0]      thr_q;
	logic [ZI_W-1:0]       zi_q;

	// tracking state
	logic [ANGLE_BITS-1:0] last_angle_q;
	logic [TIME_W-1:0]     last_time_q;
	logic [TURN_W-1:0]     turns_q;
	logic [ANGLE_BITS-1:0] snap_angle_q;
	logic [TURN_W-1:0]     snap_turns_q;
	logic [TIME_W-1:0]     snap_time_q;
	logic                  primed_q;

	// velocity working registers
	logic [DTURN_W-1:0]    dturn_q;
	logic [DANG_W-1:0]     dang_q;
	logic [TIME_W-1:0]     dt_q;
	logic [DCNT_W-1:0]     dcnt_q;
	logic                  neg_q;
	logic [VEL_W-1:0]      vel_q;

	// output register
	rsp_t                  rsp_q;
	logic                  rsp_valid_q;

	// control
	state_t                state_q;
	state_t                state_d;
	logic                  accept;
	logic                  mul_start;
	logic                  div_start;
	logic                  vel_load;
	logic                  rsp_load;

	// sample datapath
	logic [ANGLE_BITS-1:0] ang_in;
	logic [DANG_W-1:0]     jump;
	logic [DANG_W-1:0]     jump_abs;
	logic                  jump_pos;
	logic                  wrap;

	// velocity datapath
	logic [TIME_W-1:0]     elapsed;
	logic [DCNT_W-1:0]     mag_abs;
	logic [MAG_W-1:0]      mag;
	logic                  mul_done;
	logic [PROD_W-1:0]     product;
	logic                  div_done;
	logic                  div_ovf;
	logic [QUOT_W-1:0]     quot;
	logic [VEL_W-1:0]      vel_next;

	// ---------------------------------------------------------------- control

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		req_ready = 1'b0;
		mul_start = 1'b0;
		div_start = 1'b0;
		vel_load  = 1'b0;
		rsp_load  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					state_d = (req.cmd == CMD_VELOCITY) ? ST_PREP : ST_FIN;
				end
			end
			// form the signed count difference
			ST_PREP: begin
				state_d = ST_ABS;
			end
			// magnitude goes straight into the multiplier
			ST_ABS: begin
				mul_start = 1'b1;
				state_d   = ST_MUL;
			end
			ST_MUL: begin
				if (mul_done) begin
					div_start = 1'b1;
					state_d   = ST_DIV;
				end
			end
			ST_DIV: begin
				if (div_done) begin
					vel_load = 1'b1;
					state_d  = ST_FIN;
				end
			end
			// wait for the output register to free up
			ST_FIN: begin
				if (!rsp_valid_q || rsp_ready) begin
					rsp_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign accept = req_valid && req_ready;

	// ---------------------------------------------------------------- configuration

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= WRAP_THRESHOLD_RST;
			zi_q  <= ZERO_INTERVAL_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				CFG_WRAP_THRESHOLD: thr_q <= cfg_wdata[THR_W-1:0];
				CFG_ZERO_INTERVAL:  zi_q  <= cfg_wdata[ZI_W-1:0];
				default: ;
			endcase
		end
	end

	// ---------------------------------------------------------------- angle tracking

	always_comb begin
		ang_in   = {req.angle_high_byte[HI_BITS-1:0], req.angle_low_byte};
		jump     = {1'b0, ang_in} - {1'b0, last_angle_q};
		jump_abs = jump[DANG_W-1] ? (~jump + 1'b1) : jump;
		// a zero jump counts as negative, so it adds a turn
		jump_pos = !jump[DANG_W-1] && (jump != '0);
		wrap     = jump_abs >= DANG_W'(thr_q);
		elapsed  = last_time_q - snap_time_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_angle_q <= '0;
			last_time_q  <= '0;
			turns_q      <= '0;
			snap_angle_q <= '0;
			snap_turns_q <= '0;
			snap_time_q  <= '0;
			primed_q     <= 1'b0;
		end else if (accept) begin
			if (req.cmd == CMD_SAMPLE) begin
				if (!primed_q) begin
					// first sample only primes the snapshot
					snap_angle_q <= ang_in;
					snap_turns_q <= turns_q;
					snap_time_q  <= req.timestamp_us;
					primed_q     <= 1'b1;
				end else if (wrap) begin
					// forward jump means the angle wrapped backward
					turns_q <= jump_pos ? (turns_q - 1'b1) : (turns_q + 1'b1);
				end
				last_angle_q <= ang_in;
				last_time_q  <= req.timestamp_us;
			end else begin
				snap_angle_q <= last_angle_q;
				snap_turns_q <= turns_q;
				snap_time_q  <= last_time_q;
			end
		end
	end

	// ---------------------------------------------------------------- velocity

	// differences are taken against the old snapshot at the accept edge
	always_ff @(posedge clk) begin
		if (accept && (req.cmd == CMD_VELOCITY)) begin
			dturn_q <= {turns_q[TURN_W-1], turns_q} - {snap_turns_q[TURN_W-1], snap_turns_q};
			dang_q  <= {1'b0, last_angle_q} - {1'b0, snap_angle_q};
			if (elapsed == '0) begin
				dt_q <= (zi_q == '0) ? TIME_W'(1) : TIME_W'(zi_q);
			end else begin
				dt_q <= elapsed;
			end
		end
		if (state_q == ST_PREP) begin
			dcnt_q <= {dturn_q, {ANGLE_BITS{1'b0}}}
				+ {{(DCNT_W-DANG_W){dang_q[DANG_W-1]}}, dang_q};
		end
		if (mul_start) begin
			neg_q <= dcnt_q[DCNT_W-1];
		end
	end

	always_comb begin
		mag_abs = dcnt_q[DCNT_W-1] ? (~dcnt_q + 1'b1) : dcnt_q;
		mag     = {{(MAG_W-DCNT_W){1'b0}}, mag_abs};
	end

	eauv_mul u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start),
		.mag     (mag),
		.done    (mul_done),
		.product (product)
	);

	eauv_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (product),
		.den    (dt_q),
		.done   (div_done),
		.ovf    (div_ovf),
		.quot   (quot)
	);

	// quotient below 2^31 fits; anything larger clamps to the signed limits
	always_comb begin
		if (div_ovf) begin
			vel_next = neg_q ? VEL_MIN : VEL_MAX;
		end else if (neg_q) begin
			vel_next = ~{1'b0, quot} + 1'b1;
		end else begin
			vel_next = {1'b0, quot};
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			vel_q <= '0;
		end else if (vel_load) begin
			vel_q <= vel_next;
		end
	end

	// ---------------------------------------------------------------- response

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (rsp_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// position is turns above the angle bits, angle below
	always_ff @(posedge clk) begin
		if (rsp_load) begin
			rsp_q.mechanical_angle <= last_angle_q;
			rsp_q.turns            <= turns_q;
			rsp_q.position_counts  <= {turns_q, last_angle_q};
			rsp_q.velocity_cps     <= vel_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

`default_nettype wire

// ----- tb/eauv_checker.sv -----
module eauv_checker import eauv_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_wr_en,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
	input  wire logic                  req_valid,
	input  wire logic                  req_ready,
	input  wire req_t                  req,
	input  wire logic                  rsp_valid,
	input  wire logic                  rsp_ready,
	input  wire rsp_t                  rsp,
	output int                         fail_count,
	output int                         outstanding,
	output int                         readout_count,
	output int                         velocity_count,
	output int                         saturated_count,
	output int                         turn_changes
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int PRINT_CAP = 200;

	logic [THR_W-1:0]      wrap_thr;
	logic [ZI_W-1:0]       zero_iv;
	logic [ANGLE_BITS-1:0] cur_angle;
	logic [ANGLE_BITS-1:0] snap_angle;
	logic [TIME_W-1:0]     cur_time;
	logic [TIME_W-1:0]     snap_time;
	logic [TURN_W-1:0]     turn_cnt;
	logic [TURN_W-1:0]     snap_turns;
	logic                  primed;
	rsp_t                  encoder_readouts[$];
	int                    n_fail;
	int                    n_readout;
	int                    n_velocity;
	int                    n_saturated;
	int                    n_turns;

	// counts per second since the snapshot, truncated toward zero and saturated
	function automatic logic [VEL_W-1:0] rate_cps();
		longint            dturn;
		longint            dcounts;
		logic [63:0]       mag;
		logic [TIME_W-1:0] span;
		logic [127:0]      quot;
		dturn   = longint'($signed(turn_cnt)) - longint'($signed(snap_turns));
		dcounts = dturn * (longint'(1) << ANGLE_BITS) + longint'(cur_angle)
			- longint'(snap_angle);
		mag     = (dcounts < 0) ? 64'(-dcounts) : 64'(dcounts);
		span    = cur_time - snap_time;
		if (span == '0)
			span = (zero_iv != '0) ? TIME_W'(zero_iv) : TIME_W'(1);
		quot = (128'(mag) * 128'(US_PER_S)) / 128'(span);
		if (dcounts < 0)
			return (quot >= 128'(VEL_MIN)) ? VEL_MIN : VEL_W'(128'(0) - quot);
		return (quot > 128'(VEL_MAX)) ? VEL_MAX : VEL_W'(quot);
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got_v,
			input logic [63:0] want_v);
		if (n_fail < PRINT_CAP)
			$display("%0t: %s: got 0x%0h, expected 0x%0h", $realtime, what, got_v, want_v);
		n_fail++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		rsp_t                  want;
		logic [ANGLE_BITS-1:0] ang;
		int                    jump;
		if (!arst_n) begin
			wrap_thr    = WRAP_THRESHOLD_RST;
			zero_iv     = ZERO_INTERVAL_RST;
			cur_angle   = '0;
			snap_angle  = '0;
			cur_time    = '0;
			snap_time   = '0;
			turn_cnt    = '0;
			snap_turns  = '0;
			primed      = 1'b0;
			encoder_readouts.delete();
			n_fail      = 0;
			n_readout   = 0;
			n_velocity  = 0;
			n_saturated = 0;
			n_turns     = 0;
		end else begin
			if (cfg_wr_en) begin
				case (cfg_index)
					CFG_WRAP_THRESHOLD: wrap_thr = cfg_wdata[THR_W-1:0];
					CFG_ZERO_INTERVAL:  zero_iv  = cfg_wdata[ZI_W-1:0];
					default: ;
				endcase
			end

			// response first: it belongs to an earlier request
			if (rsp_valid && rsp_ready) begin
				if (encoder_readouts.size() == 0) begin
					report_mismatch("response with no request pending",
						64'(rsp.position_counts), '0);
				end else begin
					want = encoder_readouts.pop_front();
					n_readout++;
					if (rsp.mechanical_angle !== want.mechanical_angle)
						report_mismatch("mechanical_angle", 64'(rsp.mechanical_angle),
							64'(want.mechanical_angle));
					if (rsp.turns !== want.turns)
						report_mismatch("turns", 64'(rsp.turns), 64'(want.turns));
					if (rsp.position_counts !== want.position_counts)
						report_mismatch("position_counts", 64'(rsp.position_counts),
							64'(want.position_counts));
					if (rsp.velocity_cps !== want.velocity_cps)
						report_mismatch("velocity_cps", 64'(rsp.velocity_cps),
							64'(want.velocity_cps));
				end
			end

			if (req_valid && req_ready) begin
				want.velocity_cps = '0;
				if (req.cmd == CMD_SAMPLE) begin
					ang = {req.angle_high_byte[HI_BITS-1:0], req.angle_low_byte};
					if (!primed) begin
						// first sample primes the snapshot, no turn counted
						snap_angle = ang;
						snap_turns = turn_cnt;
						snap_time  = req.timestamp_us;
						primed     = 1'b1;
					end else begin
						jump = int'(ang) - int'(cur_angle);
						if ((jump < 0 ? -jump : jump) >= int'(wrap_thr)) begin
							// a rising jump means the shaft wrapped backward
							turn_cnt = (jump > 0) ? turn_cnt - 1 : turn_cnt + 1;
							n_turns++;
						end
					end
					cur_angle = ang;
					cur_time  = req.timestamp_us;
				end else begin
					want.velocity_cps = rate_cps();
					if (want.velocity_cps == VEL_MAX || want.velocity_cps == VEL_MIN)
						n_saturated++;
					n_velocity++;
					snap_angle = cur_angle;
					snap_turns = turn_cnt;
					snap_time  = cur_time;
				end
				want.mechanical_angle = cur_angle;
				want.turns            = turn_cnt;
				want.position_counts  = {turn_cnt, cur_angle};
				encoder_readouts.push_back(want);
			end
		end
		fail_count      <= n_fail;
		outstanding     <= encoder_readouts.size();
		readout_count   <= n_readout;
		velocity_count  <= n_velocity;
		saturated_count <= n_saturated;
		turn_changes    <= n_turns;
	end

endmodule

// ----- tb/tb_top.sv -----
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import eauv_pkg::*;

	localparam int PHASES      = 8;
	localparam int PHASE_ITEMS = 210;
	localparam int LONG_HOLD   = 400;
	localparam int TAIL_CYCLES = 60;
	localparam int CYCLE_LIMIT = 1000000;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_wr_en;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;
	logic                  req_valid;
	logic                  req_ready;
	req_t                  req;
	logic                  rsp_valid;
	logic                  rsp_ready;
	rsp_t                  rsp;

	int fail_count;
	int outstanding;
	int readout_count;
	int velocity_count;
	int saturated_count;
	int turn_changes;
	int cycles;

	// stimulus knobs; idle_on and hold_off_req are shared by the two driving processes
	bit                idle_on;
	bit                hold_off_req;
	int                gen_angle;
	int                motion_drift;
	logic [TIME_W-1:0] gen_time;

	encoder_angle_unwrap_velocity dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	eauv_checker readout_check (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_wr_en       (cfg_wr_en),
		.cfg_index       (cfg_index),
		.cfg_wdata       (cfg_wdata),
		.req_valid       (req_valid),
		.req_ready       (req_ready),
		.req             (req),
		.rsp_valid       (rsp_valid),
		.rsp_ready       (rsp_ready),
		.rsp             (rsp),
		.fail_count      (fail_count),
		.outstanding     (outstanding),
		.readout_count   (readout_count),
		.velocity_count  (velocity_count),
		.saturated_count (saturated_count),
		.turn_changes    (turn_changes)
	);

	// 250 MHz clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// watchdog: a hung handshake ends the run here
	initial begin
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("timeout after %0d cycles, %0d responses outstanding", cycles, outstanding);
		$display("Simulation FAILED");
		$finish;
	end

	// response side: random stall bursts plus one long hold-off on request
	initial begin
		int stall_left;
		rsp_ready  = 1'b0;
		stall_left = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				rsp_ready <= 1'b0;
				stall_left--;
			end else if (hold_off_req) begin
				// long back-pressure so the block fills and stalls its input
				hold_off_req = 1'b0;
				stall_left   = LONG_HOLD - 1;
				rsp_ready <= 1'b0;
			end else if (idle_on && $urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(0, 9);
				rsp_ready <= 1'b0;
			end else begin
				rsp_ready <= 1'b1;
			end
		end
	end

	// offer one request, with an optional idle burst first, and wait for acceptance
	task automatic push_request(input req_t r);
		@(negedge clk);
		if (idle_on && $urandom_range(0, 5) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(negedge clk);
		end
		req       <= r;
		req_valid <= 1'b1;
		@(posedge clk);
		while (!req_ready) @(posedge clk);
	endtask

	task automatic send_sample(input logic [7:0] hi, input logic [7:0] lo,
			input logic [TIME_W-1:0] ts);
		req_t r;
		r.cmd             = CMD_SAMPLE;
		r.angle_high_byte = hi;
		r.angle_low_byte  = lo;
		r.timestamp_us    = ts;
		push_request(r);
	endtask

	// payload bytes and time are don't-care here, so they are random
	task automatic send_velocity();
		req_t r;
		r.cmd             = CMD_VELOCITY;
		r.angle_high_byte = 8'($urandom);
		r.angle_low_byte  = 8'($urandom);
		r.timestamp_us    = $urandom;
		push_request(r);
	endtask

	// drop valid and wait until every response has been taken
	task automatic settle();
		@(negedge clk);
		req_valid <= 1'b0;
		while (outstanding != 0) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// mostly a shaft turning at the phase drift with jitter, some velocity
	// requests, and some raw noise samples
	task automatic random_item();
		int unsigned roll;
		int unsigned tick;
		int          jitter;
		req_t        r;
		roll              = $urandom_range(0, 99);
		r.cmd             = CMD_SAMPLE;
		r.angle_high_byte = 8'($urandom);
		r.angle_low_byte  = 8'($urandom);
		r.timestamp_us    = $urandom;
		if (roll < 18) begin
			send_velocity();
		end else begin
			if (roll < 88) begin
				jitter    = int'($urandom_range(0, 200)) - 100;
				gen_angle = ((gen_angle + motion_drift + jitter) % 4096 + 4096) % 4096;
				tick      = $urandom_range(0, 19);
				// same microsecond now and then, rarely a huge time step
				if (tick == 0)
					gen_time = gen_time;
				else if (tick == 1)
					gen_time = gen_time + $urandom;
				else
					gen_time = gen_time + $urandom_range(1, 2000);
				// upper nibble of the high byte stays random: it must be ignored
				r.angle_high_byte[HI_BITS-1:0] = HI_BITS'(gen_angle >> 8);
				r.angle_low_byte               = 8'(gen_angle);
				r.timestamp_us                 = gen_time;
			end
			push_request(r);
		end
	endtask

	initial begin
		int thr;
		int zi;
		arst_n       = 1'b0;
		cfg_wr_en    = 1'b0;
		cfg_index    = '0;
		cfg_wdata    = '0;
		req_valid    = 1'b0;
		req          = '0;
		idle_on      = 1'b1;
		hold_off_req = 1'b0;
		gen_angle    = 0;
		gen_time     = '0;
		motion_drift = 0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset settings: velocity before any sample reads the reset state
		send_velocity();
		// first sample primes, top of range, time close to wrapping
		send_sample(8'hFF, 8'hFF, 32'hFFFF_FFF0);
		// no time since the snapshot: fallback interval
		send_velocity();
		// 4095 -> 0 counts a turn up, time wraps past zero
		send_sample(8'hF0, 8'h00, 32'h0000_0010);
		send_velocity();
		// 0 -> 4095 counts a turn down, then a repeat with no jump
		send_sample(8'h0F, 8'hFF, 32'h0000_0011);
		send_sample(8'h0F, 8'hFF, 32'h0000_0011);
		send_velocity();
		send_sample(8'h00, 8'h00, 32'h0000_0012);
		send_velocity();
		// 3000 counts in one microsecond saturates high, then low
		send_sample(8'h0B, 8'hB8, 32'h0000_0013);
		send_velocity();
		send_sample(8'h00, 8'h00, 32'h0000_0014);
		send_velocity();
		// motion at the snapshot time: fallback interval with a nonzero change
		send_sample(8'h01, 8'hF4, 32'h0000_0014);
		send_velocity();
		// one count below the threshold both ways, then exactly at it
		send_sample(8'h00, 8'h00, 32'h0000_0015);
		send_sample(8'h0C, 8'hCC, 32'h0000_0016);
		send_sample(8'h00, 8'h00, 32'h0000_0017);
		send_sample(8'h0C, 8'hCD, 32'h0000_0018);

		// widest threshold, fallback register zero means one microsecond
		settle();
		write_reg(CFG_WRAP_THRESHOLD, CFG_DATA_W'(4095));
		write_reg(CFG_ZERO_INTERVAL, CFG_DATA_W'(0));
		send_velocity();
		send_sample(8'h0C, 8'hCE, 32'h0000_0018);
		send_velocity();

		// threshold zero: even a jump of zero counts a turn up
		settle();
		write_reg(CFG_WRAP_THRESHOLD, CFG_DATA_W'(0));
		send_sample(8'h0C, 8'hCE, 32'h0000_0019);
		send_sample(8'h00, 8'h00, 32'h0000_001A);

		gen_time = 32'h0000_001A;
		for (int p = 0; p < PHASES; p++) begin
			settle();
			case (p)
				0: begin
					thr = 1;
					zi  = 1;
				end
				1: begin
					thr = 4095;
					zi  = 1000000;
				end
				2: begin
					thr = 0;
					zi  = int'($urandom_range(1, 1000000));
				end
				3: begin
					thr = 3277;
					zi  = 1000;
				end
				default: begin
					thr = int'($urandom_range(1, 4095));
					zi  = int'($urandom_range(1, 1000000));
				end
			endcase
			write_reg(CFG_WRAP_THRESHOLD, CFG_DATA_W'(thr));
			write_reg(CFG_ZERO_INTERVAL, CFG_DATA_W'(zi));
			motion_drift = int'($urandom_range(0, 3000)) - 1500;
			// one phase runs into a long response stall while requests keep coming
			if (p == 3)
				hold_off_req = 1'b1;
			// last phase runs back to back on both sides
			if (p == PHASES - 1)
				idle_on = 1'b0;
			repeat (PHASE_ITEMS) random_item();
		end

		settle();
		repeat (TAIL_CYCLES) @(negedge clk);
		$display("checked %0d responses: %0d velocity requests, %0d saturated, %0d turn changes",
			readout_count, velocity_count, saturated_count, turn_changes);
		$display("covered %0d register settings incl. threshold and fallback extremes, %0d cycles",
			PHASES + 3, cycles);
		if (fail_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
